// ----- hw/rtl/cbq_pkg.sv -----
package cbq_pkg;

	// Fixed formats of the filter arithmetic
	localparam int NCOEF         = 5;
	localparam int COEF_INT_BITS = 4;
	localparam int PROD_SHIFT    = 12;
	localparam int STATE_BITS    = 48;
	localparam int BAND_BITS     = 4;
	localparam int SEL_BITS      = 3;
	localparam int KIND_BITS     = 2;
	localparam int CCOUNT_BITS   = 2;

	// Item kinds on the input channel
	typedef enum logic [KIND_BITS-1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_COEF   = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// Coefficient order inside one band's block of the table
	typedef enum logic [SEL_BITS-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} state_t;

	// Steps of one band on the shared multiplier
	typedef enum logic [2:0] {
		STEP_ADDR,
		STEP_MUL_B0,
		STEP_MUL_B1,
		STEP_MUL_B2,
		STEP_MUL_A1,
		STEP_MUL_A2,
		STEP_WB
	} step_t;

endpackage

// ----- hw/rtl/cascaded_biquad_equalizer.sv -----
// Channel   Handshake           Beat contents
// config    cfg_we              cfg_wdata = channel_count
// input     in_valid/in_stall   kind, channel, sample, band, coef_select, coef_value, block_end
// output    out_valid/out_stall filtered, out_channel, out_block_end, channel_error
//
// A sample on an active channel runs each band in seven steps on the one shared multiplier
// and accumulator, fed by the coefficient table's single read port. Flagged samples skip
// the bands and go to the emit state; coefficient writes and clears keep the sequencer idle.
// Reset restores pass-through coefficients and zero state through valid bits at once;
// there is no clearing pass. A result held by out_stall waits in the output register
// while the next beat is accepted; the sequencer stalls only when it must emit over it.
module cascaded_biquad_equalizer
	import cbq_pkg::*;
#(
	parameter int BANDS       = 10,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 32
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              cfg_we,
	input  logic [CCOUNT_BITS-1:0]                            cfg_wdata,
	input  logic                                              in_valid,
	output logic                                              in_stall,
	input  logic [KIND_BITS-1:0]                              kind,
	input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] channel,
	input  logic signed [SAMPLE_BITS-1:0]                     sample,
	input  logic [BAND_BITS-1:0]                              band,
	input  logic [SEL_BITS-1:0]                               coef_select,
	input  logic signed [COEF_BITS-1:0]                       coef_value,
	input  logic                                              block_end,
	output logic                                              out_valid,
	input  logic                                              out_stall,
	output logic signed [SAMPLE_BITS-1:0]                     filtered,
	output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] out_channel,
	output logic                                              out_block_end,
	output logic                                              channel_error
);

	localparam int CHAN_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int COEF_N    = BANDS * NCOEF;
	localparam int COEF_AW   = $clog2(COEF_N);
	localparam int ST_N      = BANDS * CHANNELS;
	localparam int ST_AW     = (ST_N > 1) ? $clog2(ST_N) : 1;
	localparam int OUT_SHIFT = COEF_BITS - COEF_INT_BITS - PROD_SHIFT;
	localparam int PROD_W    = COEF_BITS + SAMPLE_BITS;
	localparam int SH_W      = PROD_W - PROD_SHIFT;
	localparam int ACC_W     = ((SH_W > STATE_BITS) ? SH_W : STATE_BITS) + 2;

	localparam logic signed [ACC_W-1:0] Y_HI  = ACC_W'({(SAMPLE_BITS-1){1'b1}});
	localparam logic signed [ACC_W-1:0] Y_LO  = ~Y_HI;
	localparam logic signed [ACC_W-1:0] Z_HI  = ACC_W'({(STATE_BITS-1){1'b1}});
	localparam logic signed [ACC_W-1:0] Z_LO  = ~Z_HI;
	localparam logic signed [ACC_W-1:0] Y_RND = ACC_W'(1) << (OUT_SHIFT - 1);
	localparam logic [BAND_BITS-1:0]    LAST_BAND = BAND_BITS'(BANDS - 1);

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [ACC_W-1:0] v
	);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > Y_HI) begin
			r = Y_HI;
		end else if (v < Y_LO) begin
			r = Y_LO;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic signed [STATE_BITS-1:0] sat_state(
		input logic signed [ACC_W-1:0] v
	);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > Z_HI) begin
			r = Z_HI;
		end else if (v < Z_LO) begin
			r = Z_LO;
		end
		return r[STATE_BITS-1:0];
	endfunction

	// Control
	state_t                  state_q, state_nx;
	step_t                   step_q, step_nx;
	logic [BAND_BITS-1:0]    band_q;
	logic [CCOUNT_BITS-1:0]  ccount_q;
	logic                    accept;
	logic                    emit_go;
	logic                    coef_we;
	logic                    clear_all;
	logic                    in_bad;

	// Item registers
	logic [CHAN_BITS-1:0]    ch_q;
	logic                    blk_q;
	logic                    bad_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;

	// Coefficient table access
	logic [COEF_AW-1:0]      coef_wr_addr;
	logic [COEF_AW-1:0]      coef_rd_addr;
	coef_t                   rd_sel;
	logic signed [COEF_BITS-1:0] coef_val;

	// Delay state storage
	logic signed [STATE_BITS-1:0] z1_mem [ST_N];
	logic signed [STATE_BITS-1:0] z2_mem [ST_N];
	logic [ST_N-1:0]         st_vld_q;
	logic signed [STATE_BITS-1:0] z1_rd_q, z2_rd_q;
	logic                    st_rd_vld_q;
	logic signed [STATE_BITS-1:0] z1_sel, z2_sel;
	logic [ST_AW-1:0]        st_addr;
	logic                    st_we;

	// Shared multiply-accumulate
	logic signed [SAMPLE_BITS-1:0] mop;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  prod_sh;
	logic signed [ACC_W-1:0]  ysum;
	logic signed [ACC_W-1:0]  n1_q, n2_q;
	logic signed [ACC_W-1:0]  n2_fin;

	// Output register
	logic                    out_valid_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic [CHAN_BITS-1:0]    out_channel_q;
	logic                    out_block_end_q;
	logic                    channel_error_q;

	assign in_bad = (int'(channel) >= int'(ccount_q)) || (int'(channel) >= CHANNELS);

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && kind == KIND_SAMPLE) begin
					state_nx = in_bad ? ST_EMIT : ST_RUN;
				end
			end
			ST_RUN: begin
				if (step_q == STEP_WB && band_q == LAST_BAND) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		accept    = in_valid && (state_q == ST_IDLE);
		emit_go   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
		coef_we   = accept && kind == KIND_COEF && int'(band) < BANDS
			&& int'(coef_select) < NCOEF;
		clear_all = accept && kind == KIND_CLEAR;
		st_we     = (state_q == ST_RUN) && (step_q == STEP_WB);
	end

	// Step order within a band
	always_comb begin
		unique case (step_q)
			STEP_ADDR:   step_nx = STEP_MUL_B0;
			STEP_MUL_B0: step_nx = STEP_MUL_B1;
			STEP_MUL_B1: step_nx = STEP_MUL_B2;
			STEP_MUL_B2: step_nx = STEP_MUL_A1;
			STEP_MUL_A1: step_nx = STEP_MUL_A2;
			STEP_MUL_A2: step_nx = STEP_WB;
			STEP_WB:     step_nx = STEP_ADDR;
			default:     step_nx = STEP_ADDR;
		endcase
	end

	// Coefficient address set in the step before its product
	always_comb begin
		unique case (step_q)
			STEP_ADDR:   rd_sel = COEF_B0;
			STEP_MUL_B0: rd_sel = COEF_B1;
			STEP_MUL_B1: rd_sel = COEF_B2;
			STEP_MUL_B2: rd_sel = COEF_A1;
			default:     rd_sel = COEF_A2;
		endcase
	end

	assign coef_rd_addr = COEF_AW'(int'(band_q) * NCOEF + int'(rd_sel));
	assign coef_wr_addr = COEF_AW'(int'(band) * NCOEF + int'(coef_select));
	assign st_addr      = ST_AW'(int'(band_q) * CHANNELS + int'(ch_q));

	cbq_coef_store #(
		.DEPTH (COEF_N),
		.WIDTH (COEF_BITS)
	) u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (coef_we),
		.wr_addr (coef_wr_addr),
		.wr_data (coef_value),
		.rd_addr (coef_rd_addr),
		.rd_lead (step_q == STEP_ADDR),
		.rd_data (coef_val)
	);

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= STEP_ADDR;
			band_q   <= '0;
			ccount_q <= CCOUNT_BITS'(1);
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				ccount_q <= cfg_wdata;
			end
			if (accept) begin
				step_q <= STEP_ADDR;
				band_q <= '0;
			end else if (state_q == ST_RUN) begin
				step_q <= step_nx;
				if (step_q == STEP_WB) begin
					band_q <= band_q + BAND_BITS'(1);
				end
			end
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (accept && kind == KIND_SAMPLE) begin
			ch_q  <= channel;
			blk_q <= block_end;
			bad_q <= in_bad;
			x_q   <= sample;
		end else if (st_we) begin
			x_q <= y_q;
		end
	end

	// Delay-state valid bits: a clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q <= '0;
		end else if (clear_all) begin
			st_vld_q <= '0;
		end else if (st_we) begin
			st_vld_q[st_addr] <= 1'b1;
		end
	end

	// Delay-state write-back and registered read
	always_ff @(posedge clk) begin
		if (st_we) begin
			z1_mem[st_addr] <= sat_state(n1_q);
			z2_mem[st_addr] <= sat_state(n2_fin);
		end
		z1_rd_q     <= z1_mem[st_addr];
		z2_rd_q     <= z2_mem[st_addr];
		st_rd_vld_q <= st_vld_q[st_addr];
	end

	always_comb begin
		z1_sel = st_rd_vld_q ? z1_rd_q : '0;
		z2_sel = st_rd_vld_q ? z2_rd_q : '0;
	end

	// Shared multiplier: x for the b terms, y for the a terms
	always_comb begin
		if (step_q == STEP_MUL_A1 || step_q == STEP_MUL_A2) begin
			mop = y_q;
		end else begin
			mop = x_q;
		end
	end

	assign prod_sh = ACC_W'(prod_q >>> PROD_SHIFT);
	assign ysum    = prod_sh + ACC_W'(z1_sel) + Y_RND;
	assign n2_fin  = n2_q - prod_sh;

	// Multiply, then fold each product into y, z1 or z2
	always_ff @(posedge clk) begin
		prod_q <= coef_val * mop;
		unique case (step_q)
			STEP_MUL_B1: y_q  <= sat_sample(ysum >>> OUT_SHIFT);
			STEP_MUL_B2: n1_q <= prod_sh + ACC_W'(z2_sel);
			STEP_MUL_A1: n2_q <= prod_sh;
			STEP_MUL_A2: n1_q <= n1_q - prod_sh;
			default: begin
			end
		endcase
	end

	// Output register: hold while stalled, load when the sequencer emits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			filtered_q      <= x_q;
			out_channel_q   <= ch_q;
			out_block_end_q <= blk_q;
			channel_error_q <= bad_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign filtered      = filtered_q;
	assign out_channel   = out_channel_q;
	assign out_block_end = out_block_end_q;
	assign channel_error = channel_error_q;

	// Band counter stays within the cascade while filtering
	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> band_q <= LAST_BAND)
		else $error("band counter past last band");

	// Write-back of the last band hands over to the emit state
	a_last_band: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && step_q == STEP_WB && band_q == LAST_BAND
		|=> state_q == ST_EMIT)
		else $error("last band did not lead to emit");

	// A new result appears only out of the emit state
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result raised outside emit");

endmodule

// ----- hw/rtl/cbq_coef_store.sv -----
module cbq_coef_store
	import cbq_pkg::*;
#(
	parameter int DEPTH = 50,
	parameter int WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic signed [WIDTH-1:0]          wr_data,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	input  logic                             rd_lead,
	output logic signed [WIDTH-1:0]          rd_data
);

	localparam logic signed [WIDTH-1:0] COEF_ONE =
		{{(COEF_INT_BITS-1){1'b0}}, 1'b1, {(WIDTH-COEF_INT_BITS){1'b0}}};

	logic signed [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0]        vld_q;
	logic signed [WIDTH-1:0] rd_q;
	logic                    rd_vld_q;
	logic                    rd_lead_q;

	// Mark entries that hold a written value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Write and registered read of the table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q      <= mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
		rd_lead_q <= rd_lead;
	end

	// Unwritten entries read as pass-through: b0 one, others zero
	always_comb begin
		if (rd_vld_q) begin
			rd_data = rd_q;
		end else if (rd_lead_q) begin
			rd_data = COEF_ONE;
		end else begin
			rd_data = '0;
		end
	end

endmodule
